@@ src/fdrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrd_pkg
// Shared types, sizes and helpers of the frame dirty rectangle detector.
// ----------------------------------------------------------------------------
package fdrd_pkg;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 2048;
  localparam int unsigned PixelBits = 32;

  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned LineW = $clog2(MaxHeight);
  localparam int unsigned SizeW = 12;
  localparam int unsigned AddrW = ColW + LineW;
  localparam int unsigned MemDepth = MaxWidth * MaxHeight;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 48;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [SizeW-1:0] WidthReset  = SizeW'(1280);
  localparam logic [SizeW-1:0] HeightReset = SizeW'(720);
  localparam logic [ColW-1:0]  ColOnes     = '1;
  localparam logic [LineW-1:0] LineOnes    = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [PixelBits-1:0] pix;
    logic [ColW-1:0]      col;
    logic [LineW-1:0]     line;
    logic                 first;
    logic                 last;
    logic                 full;
    logic [SizeW-1:0]     width;
    logic [SizeW-1:0]     height;
  } item_t;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] maxv);
    logic [SizeW-1:0] r;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ src/frame_dirty_rect_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_dirty_rect_detector_core
// Frame difference detector that reports the dirty rectangle of each frame.
// ----------------------------------------------------------------------------
// Pixels enter in raster order at a rate of one per clock cycle, except while
// the queue is full because a frame's last pixel waits for the previous result
// to be taken; each one costs one read and one write of the previous frame
// store, which has one read port and one write port, and that pair sets the
// rate. The result of a frame passes through the queue, the compare stage
// register and the result register, and is held until taken, while pixels of
// the next frame keep flowing. The store needs no clearing pass after reset.
module frame_dirty_rect_detector_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fdrd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fdrd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] pixel_word
  input  logic [fdrd_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] changed, [1] full_frame, [12:2] rect_left, [23:13] rect_top,
  // [35:24] rect_right, [47:36] rect_bottom
  output logic [fdrd_pkg::OutDataW-1:0]  m_axis_tdata
);
  import fdrd_pkg::*;

  item_t push_item, pop_item;
  logic  q_push, q_pop, q_full, q_empty;

  fdrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_pix_i   (s_axis_tdata[PixelBits-1:0]),
    .in_ready_o (s_axis_tready),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  fdrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (pop_item),
    .empty_o (q_empty)
  );

  fdrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  a_rect_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] && !m_axis_tdata[1] |->
      ({1'b0, m_axis_tdata[12:2]} < m_axis_tdata[35:24]) &&
      ({1'b0, m_axis_tdata[23:13]} < m_axis_tdata[47:36]))
    else $error("dirty rectangle is empty or inverted");

  a_full_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |->
      m_axis_tdata[0] && (m_axis_tdata[23:2] == '0) && (m_axis_tdata[35:24] != '0))
    else $error("full frame result is malformed");

  a_no_change_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata == '0))
    else $error("unchanged result carries a rectangle");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty && !(q_full && q_push && !q_pop))
    else $error("queue popped while empty");

endmodule

@@ src/fdrd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrd_front
// Takes pixels, holds the size registers, counts raster position and decides
// at the first pixel of each frame whether the whole frame is reported.
// ----------------------------------------------------------------------------
module fdrd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fdrd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fdrd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  input  logic [fdrd_pkg::PixelBits-1:0]  in_pix_i,
  output logic                            in_ready_o,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output fdrd_pkg::item_t                 q_item_o
);
  import fdrd_pkg::*;

  logic [SizeW-1:0] frame_width_q, frame_height_q;
  logic [ColW-1:0]  col_q, col_d;
  logic [LineW-1:0] line_q, line_d;
  logic [SizeW-1:0] lw_q, lh_q, sw_q, sh_q;
  logic             lfull_q, pv_q;
  logic             first_c, last_c, full_c, accept_c, col_end_c;
  logic [SizeW-1:0] w_c, h_c;

  always_comb begin
    first_c   = (col_q == '0) && (line_q == '0);
    w_c       = first_c ? clamp_size(frame_width_q, SizeW'(MaxWidth)) : lw_q;
    h_c       = first_c ? clamp_size(frame_height_q, SizeW'(MaxHeight)) : lh_q;
    full_c    = first_c ? (!pv_q || (sw_q != w_c) || (sh_q != h_c)) : lfull_q;
    col_end_c = ({1'b0, col_q} + SizeW'(1)) >= w_c;
    last_c    = col_end_c && (({1'b0, line_q} + SizeW'(1)) >= h_c);
    accept_c  = in_valid_i && !q_full_i;
    col_d     = col_end_c ? '0 : col_q + ColW'(1);
    if (!col_end_c) begin
      line_d = line_q;
    end else if (last_c) begin
      line_d = '0;
    end else begin
      line_d = line_q + LineW'(1);
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = accept_c;
  assign q_item_o   = '{pix: in_pix_i, col: col_q, line: line_q, first: first_c,
                        last: last_c, full: full_c, width: w_c, height: h_c};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WidthReset;
      frame_height_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      line_q  <= '0;
      lw_q    <= '0;
      lh_q    <= '0;
      lfull_q <= 1'b0;
      pv_q    <= 1'b0;
      sw_q    <= '0;
      sh_q    <= '0;
    end else if (accept_c) begin
      col_q  <= col_d;
      line_q <= line_d;
      if (first_c) begin
        lw_q    <= w_c;
        lh_q    <= h_c;
        lfull_q <= full_c;
      end
      if (last_c) begin
        pv_q <= 1'b1;
        sw_q <= w_c;
        sh_q <= h_c;
      end
    end
  end

endmodule

@@ src/fdrd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrd_queue
// Short first-in first-out queue of classified pixels between the front and
// the back.
// ----------------------------------------------------------------------------
module fdrd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fdrd_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output fdrd_pkg::item_t item_o,
  output logic            empty_o
);
  import fdrd_pkg::*;

  item_t                entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   count_q;

  assign full_o  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = entries_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QueuePtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QueuePtrW+1)'(1);
      end
    end
  end

endmodule

@@ src/fdrd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrd_back
// Reads the previous frame store, compares, writes the new pixel, tracks the
// dirty rectangle and holds the result until it is taken.
// ----------------------------------------------------------------------------
module fdrd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  fdrd_pkg::item_t                q_item_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fdrd_pkg::OutDataW-1:0]  out_data_o
);
  import fdrd_pkg::*;

  logic [PixelBits-1:0] mem_q [MemDepth];
  logic [PixelBits-1:0] rd_q, fwd_pix_q, prev_c;
  logic                 fwd_q;
  item_t                b_item_q;
  logic                 b_valid_q;
  logic [ColW-1:0]      min_col_q, max_col_q, bmin_col_c, bmax_col_c, nmin_col_c, nmax_col_c;
  logic [LineW-1:0]     min_line_q, max_line_q, bmin_line_c, bmax_line_c;
  logic [LineW-1:0]     nmin_line_c, nmax_line_c;
  logic                 any_q, nany_c, diff_c, b_go_c, b_free_c;
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q, res_c;
  logic [AddrW-1:0]     a_addr_c, b_addr_c;

  assign a_addr_c = {q_item_i.line, q_item_i.col};
  assign b_addr_c = {b_item_q.line, b_item_q.col};
  assign b_go_c   = b_valid_q && (!b_item_q.last || !out_valid_q || out_ready_i);
  assign b_free_c = !b_valid_q || b_go_c;
  assign q_pop_o  = !q_empty_i && b_free_c;

  always_comb begin
    prev_c      = fwd_q ? fwd_pix_q : rd_q;
    diff_c      = !b_item_q.full && (prev_c != b_item_q.pix);
    bmin_col_c  = b_item_q.first ? ColOnes  : min_col_q;
    bmax_col_c  = b_item_q.first ? '0       : max_col_q;
    bmin_line_c = b_item_q.first ? LineOnes : min_line_q;
    bmax_line_c = b_item_q.first ? '0       : max_line_q;
    nany_c      = (b_item_q.first ? 1'b0 : any_q) || diff_c;
    nmin_col_c  = (diff_c && b_item_q.col < bmin_col_c)   ? b_item_q.col  : bmin_col_c;
    nmax_col_c  = (diff_c && b_item_q.col > bmax_col_c)   ? b_item_q.col  : bmax_col_c;
    nmin_line_c = (diff_c && b_item_q.line < bmin_line_c) ? b_item_q.line : bmin_line_c;
    nmax_line_c = (diff_c && b_item_q.line > bmax_line_c) ? b_item_q.line : bmax_line_c;
    if (b_item_q.full) begin
      res_c = {b_item_q.height, b_item_q.width, LineW'(0), ColW'(0), 1'b1, 1'b1};
    end else if (nany_c) begin
      res_c = {({1'b0, nmax_line_c} + SizeW'(1)), ({1'b0, nmax_col_c} + SizeW'(1)),
               nmin_line_c, nmin_col_c, 1'b0, 1'b1};
    end else begin
      res_c = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go_c) begin
      mem_q[b_addr_c] <= b_item_q.pix;
    end
    if (q_pop_o) begin
      rd_q      <= mem_q[a_addr_c];
      fwd_q     <= b_go_c && (b_addr_c == a_addr_c);
      fwd_pix_q <= b_item_q.pix;
      b_item_q  <= q_item_i;
    end
    if (b_go_c) begin
      min_col_q  <= nmin_col_c;
      max_col_q  <= nmax_col_c;
      min_line_q <= nmin_line_c;
      max_line_q <= nmax_line_c;
    end
    if (b_go_c && b_item_q.last) begin
      out_data_q <= res_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b_free_c) begin
        b_valid_q <= !q_empty_i;
      end
      if (b_go_c) begin
        any_q <= nany_c;
      end
      if (b_go_c && b_item_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the frame dirty rectangle detector.
// ----------------------------------------------------------------------------
// Frames of many small sizes are streamed in, with random gaps on the pixel
// side and random stalls on the result side. A predictor keeps its own copy
// of the previous frame and works out the expected rectangle of every frame.
// Each result transaction is compared with the oldest expected rectangle,
// field by field.
module tb;
  import fdrd_pkg::*;

  localparam int unsigned SETTLE      = 16;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned RAND_PIXELS = 1700;
  localparam int unsigned CALM_PIXELS = 1400;

  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [SizeW-1:0] rect_bottom;
    logic [SizeW-1:0] rect_right;
    logic [LineW-1:0] rect_top;
    logic [ColW-1:0]  rect_left;
    logic             full_frame;
    logic             changed;
  } dirty_rect_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Predictor state.
  bit [PixelBits-1:0] last_img [int unsigned];
  logic               have_prev = 1'b0;
  logic [SizeW-1:0]   prev_w = '0;
  logic [SizeW-1:0]   prev_h = '0;
  logic [SizeW-1:0]   cfg_w, cfg_h, frm_w, frm_h;
  logic               frm_full, frm_dirty;
  logic [ColW-1:0]    col_pos = '0;
  logic [ColW-1:0]    col_lo, col_hi;
  logic [LineW-1:0]   line_pos = '0;
  logic [LineW-1:0]   line_lo, line_hi;
  dirty_rect_t        pending_rects[$];

  // Stimulus state.
  bit [PixelBits-1:0]   scene_img [int unsigned];
  logic [PixelBits-1:0] pixel_q[$];
  logic [SizeW-1:0]     cur_w, cur_h;
  int unsigned          px_pushed, px_accepted;
  int unsigned          src_gap, src_quiet, sink_stall, sink_quiet, sink_hold;
  int unsigned          idle_cycles;
  int                   fails;
  bit                   calm, hold_req, hold_done, px_taken, rect_taken;

  frame_dirty_rect_detector_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [SizeW-1:0] fit_size(input logic [SizeW-1:0] req,
                                                input int unsigned limit);
    if (req == '0) begin
      return SizeW'(1);
    end
    if (32'(req) > limit) begin
      return SizeW'(limit);
    end
    return req;
  endfunction

  function automatic void track_pixel(input logic [PixelBits-1:0] pix);
    int unsigned addr;
    dirty_rect_t r;
    if (col_pos == '0 && line_pos == '0) begin
      frm_w     = fit_size(cfg_w, MaxWidth);
      frm_h     = fit_size(cfg_h, MaxHeight);
      frm_full  = !have_prev || prev_w != frm_w || prev_h != frm_h;
      frm_dirty = 1'b0;
      col_lo    = '1;
      col_hi    = '0;
      line_lo   = '1;
      line_hi   = '0;
    end
    addr = 32'({line_pos, col_pos});
    if (!frm_full && last_img[addr] != pix) begin
      if (col_pos < col_lo) col_lo = col_pos;
      if (col_pos > col_hi) col_hi = col_pos;
      if (line_pos < line_lo) line_lo = line_pos;
      if (line_pos > line_hi) line_hi = line_pos;
      frm_dirty = 1'b1;
    end
    last_img[addr] = pix;
    if (SizeW'(col_pos) + SizeW'(1) >= frm_w) begin
      col_pos = '0;
      if (SizeW'(line_pos) + SizeW'(1) >= frm_h) begin
        line_pos = '0;
        r = '0;
        if (frm_full) begin
          r.changed     = 1'b1;
          r.full_frame  = 1'b1;
          r.rect_right  = frm_w;
          r.rect_bottom = frm_h;
        end else if (frm_dirty) begin
          r.changed     = 1'b1;
          r.rect_left   = col_lo;
          r.rect_top    = line_lo;
          r.rect_right  = SizeW'(col_hi) + SizeW'(1);
          r.rect_bottom = SizeW'(line_hi) + SizeW'(1);
        end
        pending_rects.push_back(r);
        have_prev = 1'b1;
        prev_w    = frm_w;
        prev_h    = frm_h;
      end else begin
        line_pos = line_pos + LineW'(1);
      end
    end else begin
      col_pos = col_pos + ColW'(1);
    end
  endfunction

  function automatic void cmp_field(input string name, input logic [SizeW-1:0] want_v,
                                    input logic [SizeW-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fails++;
    end
  endfunction

  function automatic void check_rect(input dirty_rect_t got);
    dirty_rect_t want;
    if (pending_rects.size() == 0) begin
      $error("result transaction with nothing expected: %h", got);
      fails++;
    end else begin
      want = pending_rects.pop_front();
      cmp_field("changed", SizeW'(want.changed), SizeW'(got.changed));
      cmp_field("full_frame", SizeW'(want.full_frame), SizeW'(got.full_frame));
      cmp_field("rect_left", SizeW'(want.rect_left), SizeW'(got.rect_left));
      cmp_field("rect_top", SizeW'(want.rect_top), SizeW'(got.rect_top));
      cmp_field("rect_right", want.rect_right, got.rect_right);
      cmp_field("rect_bottom", want.rect_bottom, got.rect_bottom);
    end
  endfunction

  function automatic void offer(input int unsigned addr, input logic [PixelBits-1:0] val);
    scene_img[addr] = val;
    pixel_q.push_back(val);
    px_pushed++;
  endfunction

  // A negative edit count makes a frame of fresh random pixels.
  function automatic void send_frame(input int edits);
    int unsigned addr;
    logic [PixelBits-1:0] flip;
    for (int e = 0; e < edits; e++) begin
      addr = 32'({LineW'($urandom_range(0, cur_h - 1)),
                  ColW'($urandom_range(0, cur_w - 1))});
      flip = $urandom_range(0, 1) ? (PixelBits'(1) << $urandom_range(0, PixelBits - 1))
                                  : PixelBits'($urandom());
      if (flip == '0) flip = PixelBits'(1);
      scene_img[addr] = scene_img[addr] ^ flip;
    end
    for (int y = 0; y < int'(cur_h); y++) begin
      for (int x = 0; x < int'(cur_w); x++) begin
        addr = 32'({LineW'(y), ColW'(x)});
        if (edits < 0 || !scene_img.exists(addr)) scene_img[addr] = $urandom();
        offer(addr, scene_img[addr]);
      end
    end
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FRAME_WIDTH) begin
      cfg_w = val;
    end else if (idx == REG_FRAME_HEIGHT) begin
      cfg_h = val;
    end
  endtask

  task automatic drain();
    while (px_accepted != px_pushed || pending_rects.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_size(input logic [CfgDataW-1:0] w_val, input logic [CfgDataW-1:0] h_val);
    drain();
    write_reg(REG_FRAME_WIDTH, w_val);
    write_reg(REG_FRAME_HEIGHT, h_val);
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CfgDataW'($urandom()));
    end
    cur_w = fit_size(w_val, MaxWidth);
    cur_h = fit_size(h_val, MaxHeight);
  endtask

  always @(posedge clk_i) begin
    px_taken   = rst_ni && s_axis_tvalid && s_axis_tready;
    rect_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (rect_taken) check_rect(m_axis_tdata);
    if (px_taken) begin
      track_pixel(s_axis_tdata);
      px_accepted++;
    end
    if (!rst_ni || px_taken || rect_taken) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || px_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        s_axis_tdata  <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (src_quiet > 0) begin
          src_quiet--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(1, 17);
        end else if ($urandom_range(0, 39) == 0) begin
          src_quiet = $urandom_range(20, 120);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        sink_hold = LONG_HOLD;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_quiet > 0) begin
          sink_quiet--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          sink_stall = $urandom_range(1, 17);
        end else if ($urandom_range(0, 39) == 0) begin
          sink_quiet = $urandom_range(20, 120);
        end
      end
    end
  end

  initial begin
    int unsigned base;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    cfg_w         = WidthReset;
    cfg_h         = HeightReset;
    cur_w         = SizeW'(1);
    cur_h         = SizeW'(1);
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Single pixel frames: no previous frame, then unchanged, then all bits flipped.
    set_size(1, 1);
    scene_img[0] = '0;
    send_frame(0);
    send_frame(0);
    scene_img[0] = '1;
    send_frame(0);

    // Same area with another shape still counts as a size change.
    set_size(2, 3);
    send_frame(-1);
    set_size(3, 2);
    send_frame(-1);
    scene_img[0] ^= 32'h8000_0000;
    scene_img[{LineW'(1), ColW'(2)}] ^= 32'h0000_0001;
    send_frame(0);

    // A size written in the middle of a frame takes effect at the next frame.
    set_size(2, 1);
    offer(0, $urandom());
    set_size(1, 1);
    offer(1, $urandom());
    send_frame(0);
    drain();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '0);
    send_frame(0);
    set_size(0, 0);
    send_frame(1);

    // Results are held back long enough for the block to fill up.
    set_size(1, 1);
    @(posedge clk_i);
    hold_req = 1'b1;
    repeat (24) send_frame($urandom_range(0, 1));

    base = px_pushed;
    while (px_pushed - base < RAND_PIXELS) begin
      if (px_pushed - base > CALM_PIXELS) calm = 1'b1;
      if (!calm && $urandom_range(0, 3) != 0) begin
        set_size(CfgDataW'($urandom_range(0, 9)), CfgDataW'($urandom_range(0, 7)));
      end
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 5))
          0: begin
            send_frame(-1);
          end
          1: begin
            send_frame(0);
          end
          default: begin
            send_frame($urandom_range(1, 3));
          end
        endcase
      end
    end
    calm = 1'b1;
    drain();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/fdrd_pkg.sv
src/fdrd_front.sv
src/fdrd_queue.sv
src/fdrd_back.sv
src/frame_dirty_rect_detector_core.sv
verif/tb.sv
